// ===== rtl/core/fad_pkg.sv =====
// ----------------------------------------------------------------------------
// fad_pkg: shared types and constants of the field adaptive deinterlacer
// Holds the sample width, register indexes, depth limits, the configuration
// groups and the work entry passed from the front end to the back end.
// ----------------------------------------------------------------------------
package fad_pkg;

  // Sample and register widths.
  localparam int PIX_W  = 12;
  localparam int CFG_W  = 12;
  localparam int IDX_W  = 3;
  localparam int DEPTH_W = 4;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_LINE_WIDTH      = 3'd0;
  localparam logic [IDX_W-1:0] REG_LINE_COUNT      = 3'd1;
  localparam logic [IDX_W-1:0] REG_TOP_FIELD_FIRST = 3'd2;
  localparam logic [IDX_W-1:0] REG_PIXEL_BITS      = 3'd3;
  localparam logic [IDX_W-1:0] REG_TEMPORAL_ENABLE = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0]   RST_LINE_WIDTH = 12'd720;
  localparam logic [CFG_W-1:0]   RST_LINE_COUNT = 12'd480;
  localparam logic [DEPTH_W-1:0] RST_PIXEL_BITS = 4'd8;

  // Sample depth codes and the largest sample of each depth.
  localparam logic [DEPTH_W-1:0] DEPTH_8  = 4'd8;
  localparam logic [DEPTH_W-1:0] DEPTH_10 = 4'd10;
  localparam logic [PIX_W-1:0]   PIX_MAX_8  = 12'd255;
  localparam logic [PIX_W-1:0]   PIX_MAX_10 = 12'd1023;
  localparam logic [PIX_W-1:0]   PIX_MAX_12 = 12'd4095;

  // Depth of the queue between front and back end.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Geometry settings seen by the front end.
  typedef struct packed {
    logic [CFG_W-1:0] line_width;
    logic [CFG_W-1:0] line_count;
    logic             top_field_first;
  } front_cfg_t;

  // Arithmetic settings seen by the back end.
  typedef struct packed {
    logic [DEPTH_W-1:0] pixel_bits;
    logic               temporal_enable;
  } back_cfg_t;

  // One classified input: up to two output samples with their operands.
  // Result A is the delayed line, result B the last line itself.
  typedef struct packed {
    logic             has_a;
    logic             has_b;
    logic             keep_a;
    logic             keep_b;
    logic             eof_b;
    logic [PIX_W-1:0] above_a;
    logic [PIX_W-1:0] center_a;
    logic [PIX_W-1:0] prv_a;
    logic [PIX_W-1:0] nxt_a;
    logic [PIX_W-1:0] cur;
    logic [PIX_W-1:0] above_b;
    logic [PIX_W-1:0] prv_b;
    logic [PIX_W-1:0] nxt_b;
  } work_t;

endpackage

// ===== rtl/core/field_adaptive_deinterlacer.sv =====
// Path: a pixel's results pass the stage register, the work queue and the output register.
// Throughput: one pixel per cycle while no stall is raised; on the last line
// of a plane each pixel gives two results, so the output register paces the
// input there. Line stores are single memories read once per pixel.
// Reset: synchronous; clears position, queue and output state. The line
// stores are not cleared and no clearing pass is run.
// ----------------------------------------------------------------------------
// field_adaptive_deinterlacer: motion adaptive deinterlacer for one plane
// Front end tracks raster position and line stores, a short queue carries
// classified pixels, and the back end interpolates and drives the output.
// ----------------------------------------------------------------------------
module field_adaptive_deinterlacer #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write_en,
  input  logic [fad_pkg::IDX_W-1:0] cfg_index,
  input  logic [fad_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [fad_pkg::PIX_W-1:0] cur_pixel,
  input  logic [fad_pkg::PIX_W-1:0] prev_pixel,
  input  logic [fad_pkg::PIX_W-1:0] next_pixel,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [fad_pkg::PIX_W-1:0] out_pixel,
  output logic                      last_of_run,
  output logic                      end_of_frame
);
  import fad_pkg::*;

  front_cfg_t front_cfg;
  back_cfg_t  back_cfg;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_empty;
  work_t      q_entry;
  work_t      q_head;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      front_cfg.line_width      <= RST_LINE_WIDTH;
      front_cfg.line_count      <= RST_LINE_COUNT;
      front_cfg.top_field_first <= 1'b1;
      back_cfg.pixel_bits       <= RST_PIXEL_BITS;
      back_cfg.temporal_enable  <= 1'b1;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_LINE_WIDTH:      front_cfg.line_width      <= cfg_data;
        REG_LINE_COUNT:      front_cfg.line_count      <= cfg_data;
        REG_TOP_FIELD_FIRST: front_cfg.top_field_first <= cfg_data[0];
        REG_PIXEL_BITS:      back_cfg.pixel_bits       <= cfg_data[DEPTH_W-1:0];
        REG_TEMPORAL_ENABLE: back_cfg.temporal_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Front end: position, line stores and classification.
  fad_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (front_cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cur_pixel  (cur_pixel),
    .prev_pixel (prev_pixel),
    .next_pixel (next_pixel),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (q_entry)
  );

  // Work queue between the two ends.
  fad_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .head       (q_head)
  );

  // Back end: interpolation and output register.
  fad_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (back_cfg),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_pixel    (out_pixel),
    .last_of_run  (last_of_run),
    .end_of_frame (end_of_frame)
  );

  // The end of the plane always closes the run of its pixel.
  a_eof_closes_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_frame |-> last_of_run)
    else $error("end_of_frame without last_of_run");

  // The front end never writes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("queue written while full");

  // The back end never retires an entry that is not there.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("queue read while empty");

  // No result leaves right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

// ===== rtl/core/fad_queue.sv =====
// ----------------------------------------------------------------------------
// fad_queue: short work queue
// Small register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module fad_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  fad_pkg::work_t push_entry,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output fad_pkg::work_t head
);
  import fad_pkg::*;

  work_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // Pointer and fill tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

endmodule

// ===== rtl/core/fad_front.sv =====
// ----------------------------------------------------------------------------
// fad_front: position tracking, line stores and classification
// Accepts pixels, keeps the raster position, reads and updates the four line
// stores and builds a work entry for each pixel that produces output.
// ----------------------------------------------------------------------------
module fad_front #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                     clk,
  input  logic                     rst,
  input  fad_pkg::front_cfg_t      cfg,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [fad_pkg::PIX_W-1:0] cur_pixel,
  input  logic [fad_pkg::PIX_W-1:0] prev_pixel,
  input  logic [fad_pkg::PIX_W-1:0] next_pixel,
  input  logic                     q_full,
  output logic                     q_push,
  output fad_pkg::work_t           q_entry
);
  import fad_pkg::*;

  localparam int WB = $clog2(MAX_WIDTH);
  localparam int HB = $clog2(MAX_HEIGHT);

  typedef struct packed {
    logic [PIX_W-1:0] cur;
    logic [PIX_W-1:0] prv;
    logic [PIX_W-1:0] nxt;
    logic [WB-1:0]    x;
    logic             has_a;
    logic             has_b;
    logic             above_a_newer;
    logic             above_b_cur;
    logic             keep_a;
    logic             keep_b;
    logic             eof_b;
  } stage_t;

  logic [WB-1:0] col;
  logic [WB-1:0] w_last;
  logic [WB-1:0] x;
  logic [HB-1:0] row;
  logic [HB-1:0] h_last;
  logic [HB-1:0] r;
  logic          last_col;
  logic          last_row;
  logic          accept;
  logic          s1_go;
  logic          s1_valid;
  stage_t        s1;
  logic          fwd;
  logic [PIX_W-1:0] fwd_val;
  logic [PIX_W-1:0] older_rd;
  logic [PIX_W-1:0] newer_rd;
  logic [PIX_W-1:0] prev_rd;
  logic [PIX_W-1:0] next_rd;

  logic [PIX_W-1:0] older_mem [MAX_WIDTH];
  logic [PIX_W-1:0] newer_mem [MAX_WIDTH];
  logic [PIX_W-1:0] prev_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] next_mem  [MAX_WIDTH];

  // Last column and last row index, with zero and oversize registers limited.
  always_comb begin
    if (cfg.line_width == '0) begin
      w_last = '0;
    end else if (32'(cfg.line_width) > 32'(MAX_WIDTH)) begin
      w_last = WB'(MAX_WIDTH - 1);
    end else begin
      w_last = WB'(32'(cfg.line_width) - 32'd1);
    end
    if (cfg.line_count == '0) begin
      h_last = '0;
    end else if (32'(cfg.line_count) > 32'(MAX_HEIGHT)) begin
      h_last = HB'(MAX_HEIGHT - 1);
    end else begin
      h_last = HB'(32'(cfg.line_count) - 32'd1);
    end
  end

  // Current position, held within the present geometry.
  assign last_col = (col >= w_last);
  assign last_row = (row >= h_last);
  assign x        = last_col ? w_last : col;
  assign r        = last_row ? h_last : row;

  // Handshake: the stage register moves on whenever the queue has room.
  assign in_stall = s1_valid && q_full;
  assign accept   = in_valid && !in_stall;
  assign s1_go    = s1_valid && !q_full;

  // Raster position counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : r + 1'b1;
      end else begin
        col <= x + 1'b1;
        row <= r;
      end
    end
  end

  // Stage register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  // Stage register payload and the older-line bypass for back-to-back
  // accesses at one column.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1.cur           <= cur_pixel;
      s1.prv           <= prev_pixel;
      s1.nxt           <= next_pixel;
      s1.x             <= x;
      s1.has_a         <= (r != '0);
      s1.has_b         <= last_row;
      s1.above_a_newer <= (r == HB'(1));
      s1.above_b_cur   <= (r == '0);
      s1.keep_a        <= ~r[0] ^ cfg.top_field_first;
      s1.keep_b        <= r[0] ^ cfg.top_field_first;
      s1.eof_b         <= last_col;
      fwd              <= s1_go && (s1.x == x);
      fwd_val          <= newer_rd;
    end
  end

  // Newer, previous and next line stores: read and replaced on transfer.
  always_ff @(posedge clk) begin
    if (accept) begin
      newer_rd     <= newer_mem[x];
      prev_rd      <= prev_mem[x];
      next_rd      <= next_mem[x];
      newer_mem[x] <= cur_pixel;
      prev_mem[x]  <= prev_pixel;
      next_mem[x]  <= next_pixel;
    end
  end

  // Older line store: read on transfer, takes the retired newer sample
  // when the stage register moves on.
  always_ff @(posedge clk) begin
    if (accept) begin
      older_rd <= older_mem[x];
    end
    if (s1_go) begin
      older_mem[s1.x] <= newer_rd;
    end
  end

  // Work entry for the back end.
  always_comb begin
    q_entry.has_a    = s1.has_a;
    q_entry.has_b    = s1.has_b;
    q_entry.keep_a   = s1.keep_a;
    q_entry.keep_b   = s1.keep_b;
    q_entry.eof_b    = s1.eof_b;
    q_entry.above_a  = s1.above_a_newer ? newer_rd : (fwd ? fwd_val : older_rd);
    q_entry.center_a = newer_rd;
    q_entry.prv_a    = prev_rd;
    q_entry.nxt_a    = next_rd;
    q_entry.cur      = s1.cur;
    q_entry.above_b  = s1.above_b_cur ? s1.cur : newer_rd;
    q_entry.prv_b    = s1.prv;
    q_entry.nxt_b    = s1.nxt;
  end

  // Only pixels that produce output enter the queue.
  assign q_push = s1_go && (s1.has_a || s1.has_b);

endmodule

// ===== rtl/core/fad_back.sv =====
// ----------------------------------------------------------------------------
// fad_back: interpolation and output register
// Turns each work entry into one or two output samples: copy, spatial or
// temporal average, clamped to the sample depth.
// ----------------------------------------------------------------------------
module fad_back (
  input  logic                      clk,
  input  logic                      rst,
  input  fad_pkg::back_cfg_t        cfg,
  input  logic                      q_empty,
  input  fad_pkg::work_t            q_head,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [fad_pkg::PIX_W-1:0] out_pixel,
  output logic                      last_of_run,
  output logic                      end_of_frame
);
  import fad_pkg::*;

  logic             phase;
  logic             load;
  logic             emit_a;
  logic [PIX_W-1:0] mx;
  logic [PIX_W-1:0] pix_a;
  logic [PIX_W-1:0] pix_b;

  // One output sample from its neighbors and frame samples.
  function automatic logic [PIX_W-1:0] make_pixel(
    input logic             keep,
    input logic             temporal,
    input logic [PIX_W-1:0] above,
    input logic [PIX_W-1:0] below,
    input logic [PIX_W-1:0] center,
    input logic [PIX_W-1:0] prv,
    input logic [PIX_W-1:0] nxt,
    input logic [PIX_W-1:0] limit
  );
    logic [PIX_W:0]   sp_sum;
    logic [PIX_W:0]   tm_sum;
    logic [PIX_W-1:0] sp;
    logic [PIX_W-1:0] tm;
    logic [PIX_W-1:0] dsp;
    logic [PIX_W-1:0] dtm;
    logic [PIX_W-1:0] v;
    sp_sum = {1'b0, above} + {1'b0, below} + (PIX_W+1)'(1);
    tm_sum = {1'b0, prv} + {1'b0, nxt} + (PIX_W+1)'(1);
    sp     = sp_sum[PIX_W:1];
    tm     = tm_sum[PIX_W:1];
    dsp    = (sp >= center) ? sp - center : center - sp;
    dtm    = (tm >= center) ? tm - center : center - tm;
    if (keep) begin
      v = center;
    end else if (temporal && (dsp > dtm)) begin
      v = tm;
    end else begin
      v = sp;
    end
    return (v > limit) ? limit : v;
  endfunction

  // Largest sample of the configured depth.
  always_comb begin
    unique case (cfg.pixel_bits)
      DEPTH_8:  mx = PIX_MAX_8;
      DEPTH_10: mx = PIX_MAX_10;
      default:  mx = PIX_MAX_12;
    endcase
  end

  assign pix_a = make_pixel(q_head.keep_a, cfg.temporal_enable, q_head.above_a, q_head.cur,
                            q_head.center_a, q_head.prv_a, q_head.nxt_a, mx);
  assign pix_b = make_pixel(q_head.keep_b, cfg.temporal_enable, q_head.above_b, q_head.cur,
                            q_head.cur, q_head.prv_b, q_head.nxt_b, mx);

  // The delayed line goes first; the entry retires after its last sample.
  assign load   = !out_valid || !out_stall;
  assign emit_a = q_head.has_a && !phase;
  assign q_pop  = load && !q_empty && !(emit_a && q_head.has_b);

  // Control: output valid and the second-sample phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (load) begin
      out_valid <= !q_empty;
      if (!q_empty) begin
        phase <= emit_a && q_head.has_b;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      if (emit_a) begin
        out_pixel    <= pix_a;
        last_of_run  <= !q_head.has_b;
        end_of_frame <= 1'b0;
      end else begin
        out_pixel    <= pix_b;
        last_of_run  <= 1'b1;
        end_of_frame <= q_head.eof_b;
      end
    end
  end

endmodule
